FILE: src/psm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_pkg - shared types and constants for the point symmetry mirror
// Word layouts for input points and result copies, configuration register
// indexes and symmetry mode codes.
// ----------------------------------------------------------------------------
package psm_pkg;

    // coordinate and field widths
    localparam int COORD_BITS    = 16;
    localparam int PRESS_BITS    = 16;
    localparam int IDX_BITS      = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;

    // symmetry mode codes; the spare code gives the original point only
    typedef enum logic [2:0] {
        MODE_HORIZ     = 3'd0,
        MODE_VERT      = 3'd1,
        MODE_DIAG45    = 3'd2,
        MODE_DIAG135   = 3'd3,
        MODE_ROT180    = 3'd4,
        MODE_ROT90     = 3'd5,
        MODE_COMPOSITE = 3'd6
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE        = 3'd0,
        CFG_CENTER_X    = 3'd1,
        CFG_CENTER_Y    = 3'd2,
        CFG_AXIS_FLAGS  = 3'd3,
        CFG_WIDTH_ODD   = 3'd4,
        CFG_HEIGHT_ODD  = 3'd5
    } cfg_index_t;

    // input point word
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic        [PRESS_BITS-1:0] point_pressure;
    } point_t;

    // result copy word
    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic        [PRESS_BITS-1:0] out_pressure;
        logic        [IDX_BITS-1:0]   copy_index;
        logic                         last_copy;
    } result_t;

endpackage

FILE: src/point_symmetry_mirror.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_symmetry_mirror - symmetric copies of stroke points
// Emits each input point followed by its mirrored or rotated copies about a
// configured center, one copy per clock, through a five stage pipeline.
// ----------------------------------------------------------------------------
// A point accepted on start (with busy low) yields 1, 2, 4 or up to 16
// result words, one per clock, each on the result port for a single cycle
// with result_valid high; the first word is copy 0, the point itself. A
// copy sequencer issues one copy per clock and holds each point until its
// last copy is issued; a new point is taken on the cycle its last copy is
// issued: with one copy per point the block takes a point every clock.
// Result words are always taken, so nothing downstream can slow the block.
// Configuration writes are accepted at once (cfg_ready is always high) and
// must only be issued while no point is in flight.
module point_symmetry_mirror (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  psm_pkg::point_t                       point,
    output logic                                  result_valid,
    output psm_pkg::result_t                      result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [psm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import psm_pkg::*;

    // offsets from center grow by at most one bit per mirror step
    localparam int OFS_BITS = COORD_BITS + 4;
    localparam int SUM_BITS = OFS_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    // mirror steps applied to one copy, in order h, v, d45, d135
    typedef struct packed {
        logic h;
        logic v;
        logic d45;
        logic d135;
        logic par;
    } copy_op_t;

    // side information that travels with each copy
    typedef struct packed {
        copy_op_t              op;
        logic [PRESS_BITS-1:0] pressure;
        logic [IDX_BITS-1:0]   idx;
        logic                  last;
    } copy_tag_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] c;
        begin
            if (v > SAT_HI)
            begin
                c = SAT_HI;
            end
            else if (v < SAT_LO)
            begin
                c = SAT_LO;
            end
            else
            begin
                c = v;
            end
            return c[COORD_BITS-1:0];
        end
    endfunction

    // configuration registers
    logic [2:0]                   mode_reg;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic [3:0]                   axis_flags_reg;
    logic                         width_odd_reg;
    logic                         height_odd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            axis_flags_reg <= '0;
            width_odd_reg  <= 1'b0;
            height_odd_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[2:0];
                CFG_CENTER_X:   center_x_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_AXIS_FLAGS: axis_flags_reg <= cfg_data[3:0];
                CFG_WIDTH_ODD:  width_odd_reg  <= cfg_data[0];
                CFG_HEIGHT_ODD: height_odd_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // copy sequencer state
    logic                gen_active_reg;
    logic [IDX_BITS-1:0] gen_cnt_reg;
    logic [IDX_BITS-1:0] gen_last_reg;
    point_t              gen_point_reg;
    logic [IDX_BITS-1:0] gen_last_next;
    logic                gen_at_last;
    logic                accept;
    logic [2:0]          flag_count;

    assign gen_at_last = (gen_cnt_reg == gen_last_reg);
    assign busy        = gen_active_reg && !gen_at_last;
    assign accept      = start && !busy;

    // number of copies minus one for the current mode
    always_comb
    begin
        flag_count = 3'(axis_flags_reg[0]) + 3'(axis_flags_reg[1])
                   + 3'(axis_flags_reg[2]) + 3'(axis_flags_reg[3]);
        unique case (mode_reg)
            MODE_HORIZ, MODE_VERT, MODE_DIAG45, MODE_DIAG135, MODE_ROT180:
                gen_last_next = IDX_BITS'(1);
            MODE_ROT90:
                gen_last_next = IDX_BITS'(3);
            MODE_COMPOSITE:
                gen_last_next = IDX_BITS'((5'd1 << flag_count) - 5'd1);
            default:
                gen_last_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_active_reg <= 1'b0;
            gen_cnt_reg    <= '0;
            gen_last_reg   <= '0;
        end
        else if (accept)
        begin
            gen_active_reg <= 1'b1;
            gen_cnt_reg    <= '0;
            gen_last_reg   <= gen_last_next;
        end
        else if (gen_active_reg)
        begin
            if (gen_at_last)
            begin
                gen_active_reg <= 1'b0;
            end
            else
            begin
                gen_cnt_reg <= gen_cnt_reg + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gen_point_reg <= point;
        end
    end

    // mirror steps for the copy being issued
    copy_op_t   issue_op;
    logic [1:0] rank_v;
    logic [1:0] rank_d45;
    logic [1:0] rank_d135;

    always_comb
    begin
        issue_op  = '0;
        rank_v    = 2'(axis_flags_reg[0]);
        rank_d45  = 2'(axis_flags_reg[0]) + 2'(axis_flags_reg[1]);
        rank_d135 = 2'(axis_flags_reg[0]) + 2'(axis_flags_reg[1])
                  + 2'(axis_flags_reg[2]);
        issue_op.par = 1'b1;
        unique case (mode_reg)
            MODE_HORIZ:   issue_op.h    = (gen_cnt_reg == IDX_BITS'(1));
            MODE_VERT:    issue_op.v    = (gen_cnt_reg == IDX_BITS'(1));
            MODE_DIAG45:  issue_op.d45  = (gen_cnt_reg == IDX_BITS'(1));
            MODE_DIAG135: issue_op.d135 = (gen_cnt_reg == IDX_BITS'(1));
            MODE_ROT180:
            begin
                issue_op.h = (gen_cnt_reg == IDX_BITS'(1));
                issue_op.v = (gen_cnt_reg == IDX_BITS'(1));
            end
            MODE_ROT90:
            begin
                // quarter turns built from unshifted mirrors
                issue_op.par = 1'b0;
                issue_op.h   = (gen_cnt_reg == IDX_BITS'(1)) || (gen_cnt_reg == IDX_BITS'(2));
                issue_op.v   = (gen_cnt_reg == IDX_BITS'(2)) || (gen_cnt_reg == IDX_BITS'(3));
                issue_op.d45 = (gen_cnt_reg == IDX_BITS'(1)) || (gen_cnt_reg == IDX_BITS'(3));
            end
            MODE_COMPOSITE:
            begin
                // bit j of the index picks the j-th enabled axis
                issue_op.h    = axis_flags_reg[0] && gen_cnt_reg[0];
                issue_op.v    = axis_flags_reg[1] && gen_cnt_reg[rank_v];
                issue_op.d45  = axis_flags_reg[2] && gen_cnt_reg[rank_d45];
                issue_op.d135 = axis_flags_reg[3] && gen_cnt_reg[rank_d135];
            end
            default:      ;
        endcase
    end

    // stage 1: issued copy
    logic      p1_valid_reg;
    copy_tag_t p1_tag_reg;
    logic signed [COORD_BITS-1:0] p1_x_reg;
    logic signed [COORD_BITS-1:0] p1_y_reg;

    // stage 2: offsets from center
    logic      p2_valid_reg;
    copy_tag_t p2_tag_reg;
    logic signed [OFS_BITS-1:0] p2_dx_reg;
    logic signed [OFS_BITS-1:0] p2_dy_reg;

    // stage 3: after horizontal and vertical mirrors
    logic      p3_valid_reg;
    copy_tag_t p3_tag_reg;
    logic signed [OFS_BITS-1:0] p3_dx_reg;
    logic signed [OFS_BITS-1:0] p3_dy_reg;

    // stage 4: after diagonal mirrors
    logic      p4_valid_reg;
    copy_tag_t p4_tag_reg;
    logic signed [OFS_BITS-1:0] p4_dx_reg;
    logic signed [OFS_BITS-1:0] p4_dy_reg;

    // output word
    logic    result_valid_reg;
    result_t result_reg;

    logic signed [SUM_BITS-1:0] out_x_sum;
    logic signed [SUM_BITS-1:0] out_y_sum;

    assign out_x_sum = SUM_BITS'(center_x_reg) + SUM_BITS'(p4_dx_reg);
    assign out_y_sum = SUM_BITS'(center_y_reg) + SUM_BITS'(p4_dy_reg);

    // valid bits through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
            p4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg     <= gen_active_reg;
            p2_valid_reg     <= p1_valid_reg;
            p3_valid_reg     <= p2_valid_reg;
            p4_valid_reg     <= p3_valid_reg;
            result_valid_reg <= p4_valid_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        // issue
        p1_tag_reg.op       <= issue_op;
        p1_tag_reg.pressure <= gen_point_reg.point_pressure;
        p1_tag_reg.idx      <= gen_cnt_reg;
        p1_tag_reg.last     <= gen_at_last;
        p1_x_reg            <= gen_point_reg.point_x;
        p1_y_reg            <= gen_point_reg.point_y;

        // offsets from center
        p2_tag_reg <= p1_tag_reg;
        p2_dx_reg  <= OFS_BITS'(p1_x_reg) - OFS_BITS'(center_x_reg);
        p2_dy_reg  <= OFS_BITS'(p1_y_reg) - OFS_BITS'(center_y_reg);

        // horizontal and vertical mirrors, minus one on odd brush size
        p3_tag_reg <= p2_tag_reg;
        if (p2_tag_reg.op.h)
        begin
            p3_dx_reg <= (p2_tag_reg.op.par && width_odd_reg) ? ~p2_dx_reg : -p2_dx_reg;
        end
        else
        begin
            p3_dx_reg <= p2_dx_reg;
        end
        if (p2_tag_reg.op.v)
        begin
            p3_dy_reg <= (p2_tag_reg.op.par && height_odd_reg) ? ~p2_dy_reg : -p2_dy_reg;
        end
        else
        begin
            p3_dy_reg <= p2_dy_reg;
        end

        // diagonal mirrors: 45 swaps and negates, 135 swaps
        p4_tag_reg <= p3_tag_reg;
        unique case ({p3_tag_reg.op.d45, p3_tag_reg.op.d135})
            2'b11:
            begin
                p4_dx_reg <= -p3_dx_reg;
                p4_dy_reg <= -p3_dy_reg;
            end
            2'b10:
            begin
                p4_dx_reg <= -p3_dy_reg;
                p4_dy_reg <= -p3_dx_reg;
            end
            2'b01:
            begin
                p4_dx_reg <= p3_dy_reg;
                p4_dy_reg <= p3_dx_reg;
            end
            default:
            begin
                p4_dx_reg <= p3_dx_reg;
                p4_dy_reg <= p3_dy_reg;
            end
        endcase

        // back to absolute coordinates, saturated
        result_reg.out_x        <= sat_coord(out_x_sum);
        result_reg.out_y        <= sat_coord(out_y_sum);
        result_reg.out_pressure <= p4_tag_reg.pressure;
        result_reg.copy_index   <= p4_tag_reg.idx;
        result_reg.last_copy    <= p4_tag_reg.last;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // an accepted point shows its original copy after the pipeline delay
    a_first_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 (result_valid && result.copy_index == '0))
        else $error("original copy missing after accepted point");

    // copies of one point leave back to back with rising index
    a_copy_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_copy) |=>
            (result_valid && result.copy_index == IDX_BITS'($past(result.copy_index) + 1'b1)))
        else $error("copy sequence broken");

    // the sequencer never runs past the final copy of a point
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gen_active_reg |-> (gen_cnt_reg <= gen_last_reg))
        else $error("copy counter beyond last copy");
`endif

endmodule

FILE: dv/point_symmetry_mirror_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_symmetry_mirror_test - self-checking bench for the symmetry mirror
// Drives stroke points and register writes from one ordered event list and
// predicts every mirrored or rotated copy in a shadow model. Each result
// word is compared field by field with the oldest predicted copy.
// ----------------------------------------------------------------------------
module point_symmetry_mirror_test;

    import psm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_POINTS = 270;
    localparam int NO_GAP_TAIL   = 40;
    localparam int HOLD_OFF      = 3;
    localparam int TAIL_CYCLES   = 24;

    localparam logic [COORD_BITS-1:0] C_MIN = 16'h8000;
    localparam logic [COORD_BITS-1:0] C_MAX = 16'h7FFF;

    // spare mode code and register indexes with no register behind them
    localparam logic [2:0]              MODE_SPARE = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG_HI = 3'd7;

    // mirror axis codes, equal to the matching single-mirror mode codes
    localparam int AXIS_HORIZ   = 0;
    localparam int AXIS_VERT    = 1;
    localparam int AXIS_DIAG45  = 2;

    typedef enum {EV_POINT, EV_CONFIG, EV_DRAIN} ev_kind_e;

    typedef struct {
        ev_kind_e                 kind;
        point_t                   pt;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        bit                       gaps;
    } pen_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    point_t point = '0;
    logic result_valid;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // shadow copy of the configuration registers
    logic [2:0]                   mode_reg = '0;
    logic signed [COORD_BITS-1:0] center_x_reg = '0;
    logic signed [COORD_BITS-1:0] center_y_reg = '0;
    logic [3:0]                   axis_reg = '0;
    logic                         width_odd_reg = 1'b0;
    logic                         height_odd_reg = 1'b0;

    pen_event_t pen_events[$];
    result_t    copies_due[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         gap_left = 0;
    int         quiet_cycles = 0;
    bit         gaps_on = 1'b0;

    point_symmetry_mirror uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point        (point),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // clamp to the signed coordinate range
    function automatic logic [COORD_BITS-1:0] saturate(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return COORD_BITS'(v);
    endfunction

    // reflect a point about one axis through the configured center
    function automatic void apply_axis(input int axis, inout longint px, inout longint py);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        cx = longint'(center_x_reg);
        cy = longint'(center_y_reg);
        dx = px - cx;
        dy = py - cy;
        case (axis)
            AXIS_HORIZ:  px = cx - dx - longint'(width_odd_reg);
            AXIS_VERT:   py = cy - dy - longint'(height_odd_reg);
            AXIS_DIAG45:
            begin
                px = cx - dy;
                py = cy - dx;
            end
            default:
            begin
                px = cx + dy;
                py = cy + dx;
            end
        endcase
    endfunction

    function automatic void push_copy(int k, longint x, longint y,
                                      logic [PRESS_BITS-1:0] pr, bit last);
        result_t r;
        r.out_x        = saturate(x);
        r.out_y        = saturate(y);
        r.out_pressure = pr;
        r.copy_index   = IDX_BITS'(k);
        r.last_copy    = last;
        copies_due.insert(copies_due.size(), r);
    endfunction

    // all copies of one accepted point, in output order
    function automatic void reflect_point(point_t p);
        longint x;
        longint y;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint nx;
        longint ny;
        logic [PRESS_BITS-1:0] pr;
        int axes[4];
        int n_axes;
        int n_copies;
        x = longint'(p.point_x);
        y = longint'(p.point_y);
        pr = p.point_pressure;
        cx = longint'(center_x_reg);
        cy = longint'(center_y_reg);
        dx = x - cx;
        dy = y - cy;
        nx = x;
        ny = y;
        n_axes = 0;
        case (mode_reg)
            MODE_HORIZ, MODE_VERT, MODE_DIAG45, MODE_DIAG135:
            begin
                apply_axis(int'(mode_reg), nx, ny);
                push_copy(0, x, y, pr, 1'b0);
                push_copy(1, nx, ny, pr, 1'b1);
            end
            MODE_ROT180:
            begin
                push_copy(0, x, y, pr, 1'b0);
                push_copy(1, cx - dx - longint'(width_odd_reg),
                          cy - dy - longint'(height_odd_reg), pr, 1'b1);
            end
            MODE_ROT90:
            begin
                push_copy(0, x, y, pr, 1'b0);
                push_copy(1, cx - dy, cy + dx, pr, 1'b0);
                push_copy(2, cx - dx, cy - dy, pr, 1'b0);
                push_copy(3, cx + dy, cy - dx, pr, 1'b1);
            end
            MODE_COMPOSITE:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (axis_reg[j])
                    begin
                        axes[n_axes] = j;
                        n_axes++;
                    end
                end
                n_copies = 1 << n_axes;
                // bit j of the copy index selects the j-th enabled axis
                for (int k = 0; k < n_copies; k++)
                begin
                    nx = x;
                    ny = y;
                    for (int j = 0; j < n_axes; j++)
                        if ((k >> j) & 1)
                            apply_axis(axes[j], nx, ny);
                    push_copy(k, nx, ny, pr, k == n_copies - 1);
                end
            end
            default: push_copy(0, x, y, pr, 1'b1);
        endcase
    endfunction

    function automatic void write_shadow_reg(logic [CFG_IDX_BITS-1:0] idx,
                                             logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_MODE:       mode_reg = data[2:0];
            CFG_CENTER_X:   center_x_reg = data;
            CFG_CENTER_Y:   center_y_reg = data;
            CFG_AXIS_FLAGS: axis_reg = data[3:0];
            CFG_WIDTH_ODD:  width_odd_reg = data[0];
            CFG_HEIGHT_ODD: height_odd_reg = data[0];
            default: ;
        endcase
    endfunction

    // driver: retire accepted words, then present the next event
    always @(posedge clk)
    begin : drive_events
        logic start_next;
        logic cfg_next;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            start_next = 1'b0;
            cfg_next   = 1'b0;
            if (start && !busy)
            begin
                reflect_point(point);
                pen_events.delete(0);
            end
            if (cfg_valid && cfg_ready)
            begin
                write_shadow_reg(cfg_index, cfg_data);
                pen_events.delete(0);
            end
            // idle once every copy has come and none is on the port
            if (copies_due.size() == 0 && !result_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (gap_left > 0)
                gap_left--;
            else if (pen_events.size() != 0)
            begin
                case (pen_events[0].kind)
                    EV_POINT:
                    begin
                        if (pen_events[0].gaps && $urandom_range(0, 9) == 0)
                            gap_left = $urandom_range(0, 10);
                        else
                        begin
                            start_next = 1'b1;
                            point <= pen_events[0].pt;
                        end
                    end
                    EV_CONFIG:
                    begin
                        if (quiet_cycles >= HOLD_OFF)
                        begin
                            cfg_next = 1'b1;
                            cfg_index <= pen_events[0].idx;
                            cfg_data  <= pen_events[0].data;
                        end
                    end
                    default:
                    begin
                        if (quiet_cycles >= HOLD_OFF)
                            pen_events.delete(0);
                    end
                endcase
            end
            start     <= start_next;
            cfg_valid <= cfg_next;
        end
    end

    // monitor: compare each result word with the oldest predicted copy
    always @(posedge clk)
    begin : check_copies
        result_t want;
        if (rst_n && result_valid)
        begin
            if (copies_due.size() == 0)
            begin
                $error("unexpected result word: x %0d y %0d copy %0d",
                       result.out_x, result.out_y, result.copy_index);
                mismatches++;
            end
            else
            begin
                want = copies_due.pop_front();
                if (result.out_x !== want.out_x)
                begin
                    $error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
                    mismatches++;
                end
                if (result.out_y !== want.out_y)
                begin
                    $error("out_y: expected %0d, got %0d", want.out_y, result.out_y);
                    mismatches++;
                end
                if (result.out_pressure !== want.out_pressure)
                begin
                    $error("out_pressure: expected %0d, got %0d",
                           want.out_pressure, result.out_pressure);
                    mismatches++;
                end
                if (result.copy_index !== want.copy_index)
                begin
                    $error("copy_index: expected %0d, got %0d",
                           want.copy_index, result.copy_index);
                    mismatches++;
                end
                if (result.last_copy !== want.last_copy)
                begin
                    $error("last_copy: expected %0d, got %0d",
                           want.last_copy, result.last_copy);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                             logic [PRESS_BITS-1:0] pr);
        pen_event_t ev;
        ev.kind = EV_POINT;
        ev.pt   = {x, y, pr};
        ev.idx  = '0;
        ev.data = '0;
        ev.gaps = gaps_on;
        pen_events.insert(pen_events.size(), ev);
    endtask

    task automatic add_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        pen_event_t ev;
        ev.kind = EV_CONFIG;
        ev.pt   = '0;
        ev.idx  = idx;
        ev.data = data;
        ev.gaps = 1'b0;
        pen_events.insert(pen_events.size(), ev);
    endtask

    task automatic add_drain();
        pen_event_t ev;
        ev.kind = EV_DRAIN;
        ev.pt   = '0;
        ev.idx  = '0;
        ev.data = '0;
        ev.gaps = 1'b0;
        pen_events.insert(pen_events.size(), ev);
    endtask

    // narrow register value with random junk above the used bits
    function automatic logic [CFG_DATA_BITS-1:0] narrow_word(int v, int bits);
        logic [CFG_DATA_BITS-1:0] mask;
        logic [CFG_DATA_BITS-1:0] junk;
        mask = (CFG_DATA_BITS'(1) << bits) - 1'b1;
        junk = $urandom_range(0, 1) ? CFG_DATA_BITS'($urandom) : '0;
        return (junk & ~mask) | (CFG_DATA_BITS'(v) & mask);
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // stimulus list, reset and end of run
    initial
    begin
        int planned;
        int burst;
        int m;
        logic [PRESS_BITS-1:0] pr;

        // extremes under the reset settings
        add_point(C_MAX, C_MIN, 16'hFFFF);
        add_point(C_MIN, C_MAX, 16'h0000);

        // odd brush and extreme center, each mirror mode
        add_cfg(CFG_WIDTH_ODD, 16'd1);
        add_cfg(CFG_HEIGHT_ODD, 16'd1);
        add_cfg(CFG_CENTER_X, C_MAX);
        add_cfg(CFG_CENTER_Y, C_MIN);
        add_point(C_MIN, C_MAX, 16'h0001);
        add_point(C_MAX, C_MIN, 16'h8000);
        add_cfg(CFG_MODE, 16'(MODE_VERT));
        add_point(16'h0000, C_MAX, 16'h5A5A);
        add_point(C_MIN, C_MIN, 16'hA5A5);
        add_cfg(CFG_MODE, 16'(MODE_DIAG45));
        add_point(C_MIN, C_MAX, 16'h1234);
        add_point(16'h0000, 16'h0000, 16'hFFFF);
        add_cfg(CFG_MODE, 16'(MODE_DIAG135));
        add_point(C_MIN, C_MAX, 16'h4321);
        add_point(16'h0000, 16'h0000, 16'h0000);
        add_cfg(CFG_MODE, 16'(MODE_ROT180));
        add_point(C_MAX, C_MAX, 16'h00FF);
        add_point(C_MIN, C_MIN, 16'hFF00);

        // even brush at the origin: rotation overflow and rotation by 90
        add_cfg(CFG_CENTER_X, 16'h0000);
        add_cfg(CFG_CENTER_Y, 16'h0000);
        add_cfg(CFG_WIDTH_ODD, 16'd0);
        add_cfg(CFG_HEIGHT_ODD, 16'd0);
        add_point(C_MIN, C_MIN, 16'h7777);
        add_cfg(CFG_MODE, 16'(MODE_ROT90));
        add_point(C_MAX, C_MIN, 16'h1111);
        add_point(16'h0005, 16'hFFFD, 16'h2222);
        add_drain();

        // composite with no axis, all four axes and a sparse subset
        add_cfg(CFG_MODE, 16'(MODE_COMPOSITE));
        add_cfg(CFG_AXIS_FLAGS, 16'h0000);
        add_point(16'h04D2, 16'hFFFF, 16'h3333);
        add_cfg(CFG_CENTER_X, 16'hFFF9);
        add_cfg(CFG_CENTER_Y, 16'h0009);
        add_cfg(CFG_WIDTH_ODD, 16'd1);
        add_cfg(CFG_AXIS_FLAGS, 16'h000F);
        add_point(16'h0064, 16'hFF38, 16'h4444);
        add_cfg(CFG_AXIS_FLAGS, 16'h0005);
        add_point(C_MIN, C_MAX, 16'h5555);

        // spare mode gives the point alone
        add_cfg(CFG_MODE, 16'(MODE_SPARE));
        add_point(C_MAX, 16'h0000, 16'h6666);

        // random phases of settings and points
        planned = 0;
        while (planned < RANDOM_POINTS)
        begin
            burst = $urandom_range(3, 30);
            gaps_on = (planned < RANDOM_POINTS - NO_GAP_TAIL) && ($urandom_range(0, 3) != 0);
            m = ($urandom_range(0, 9) < 4) ? int'(MODE_COMPOSITE) : $urandom_range(0, 7);
            add_cfg(CFG_MODE, narrow_word(m, 3));
            if ($urandom_range(0, 1))
                add_cfg(CFG_CENTER_X, rand_coord());
            if ($urandom_range(0, 1))
                add_cfg(CFG_CENTER_Y, rand_coord());
            if ($urandom_range(0, 1))
                add_cfg(CFG_AXIS_FLAGS, narrow_word($urandom_range(0, 15), 4));
            if ($urandom_range(0, 2) == 0)
                add_cfg(CFG_WIDTH_ODD, narrow_word($urandom_range(0, 1), 1));
            if ($urandom_range(0, 2) == 0)
                add_cfg(CFG_HEIGHT_ODD, narrow_word($urandom_range(0, 1), 1));
            if ($urandom_range(0, 15) == 0)
                add_cfg($urandom_range(0, 1) ? CFG_NO_REG_LO : CFG_NO_REG_HI,
                        CFG_DATA_BITS'($urandom));
            for (int i = 0; i < burst; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       pr = '0;
                    1:       pr = '1;
                    default: pr = PRESS_BITS'($urandom);
                endcase
                add_point(rand_coord(), rand_coord(), pr);
                if ($urandom_range(0, 40) == 0)
                    add_drain();
            end
            planned += burst;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pen_events.size() != 0)
            @(posedge clk);
        while (copies_due.size() != 0 || result_valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && copies_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
